### hw/rtl/khc_pkg.sv
// khc_pkg: shared widths, types and helpers for the k-mer histogram counter.
// No dependencies; imported by khc_count_ram and kmer_histogram_counter_top.

package khc_pkg;

  localparam int unsigned IDX_W   = 16;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned DEPTH   = 1 << IDX_W;
  localparam int unsigned KLEN_W  = 4;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [KLEN_W-1:0] klen_t;

  localparam cnt_t CNT_MAX = '1;

  // Configuration register indexes
  localparam int unsigned REG_KMER_LEN = 0;

  // Write request into the count table
  typedef struct packed {
    logic en;
    idx_t addr;
    cnt_t data;
  } ram_wr_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? CNT_MAX : v + cnt_t'(1);
  endfunction

endpackage

### hw/rtl/kmer_histogram_counter_top.sv
// kmer_histogram_counter_top: k-mer counting stream block with APB register.
// Depends on khc_pkg and khc_count_ram.

// Takes one request per cycle unless clearing or back-pressured. The k-mer
// window is updated as a symbol is taken and the table entry is read in the
// same cycle; stage 1 then adds one (saturating), writes it back and loads the
// output register (a read request, tuser set, loads the count unchanged).
// Back-to-back hits on the same k-mer are forwarded from the last write. After
// reset all 65536 table entries are zeroed by a clearing pass, one entry per
// cycle, during which s_axis_tready stays low; the register port works throughout.
module kmer_histogram_counter_top #(
  parameter int unsigned SYMBOL_BITS = 2,
  parameter int unsigned K_MAX       = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // symbol[1:0], gene_start[2], read_index[18:3], zero
  input  logic        s_axis_tuser,  // mode
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // kmer_index[15:0], kmer_count[47:16], total_kmers[79:48]
  output logic        m_axis_tuser   // is_read_reply
);
  import khc_pkg::*;

  localparam int unsigned KW_W = 6;

  // Register port
  klen_t kmer_len_q;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'(REG_KMER_LEN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q <= klen_t'(3);
    end else if (cfg_wr) begin
      kmer_len_q <= pwdata[KLEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == 1'(REG_KMER_LEN)) ? {{(32-KLEN_W){1'b0}}, kmer_len_q} : '0;

  // Clearing pass
  logic clearing_q;
  idx_t clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + idx_t'(1);
      if (clr_addr_q == '1) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Request fields
  logic                   in_mode;
  logic [1:0]             in_symbol;
  logic                   in_start;
  idx_t                   in_ridx;
  logic [SYMBOL_BITS+1:0] sym_ext;
  logic [SYMBOL_BITS-1:0] sym_m;

  assign in_mode   = s_axis_tuser;
  assign in_symbol = s_axis_tdata[1:0];
  assign in_start  = s_axis_tdata[2];
  assign in_ridx   = s_axis_tdata[18:3];
  assign sym_ext   = (SYMBOL_BITS+2)'(in_symbol);
  assign sym_m     = sym_ext[SYMBOL_BITS-1:0];

  // Handshake across the pipe
  logic s1_valid_q, s1_read_q;
  idx_t s1_idx_q;
  logic out_valid_q;
  logic s1_adv, in_acc;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !clearing_q && (!s1_valid_q || s1_adv);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Window update
  idx_t                     window_q, window_d;
  klen_t                    fill_q, fill_d;
  klen_t                    k_eff;
  logic [KW_W-1:0]          kbits;
  idx_t                     kmask;
  logic [IDX_W+SYMBOL_BITS-1:0] shifted;
  logic                     count_req;
  idx_t                     count_idx;

  always_comb begin
    if (kmer_len_q == '0) begin
      k_eff = klen_t'(1);
    end else if (kmer_len_q > klen_t'(K_MAX)) begin
      k_eff = klen_t'(K_MAX);
    end else begin
      k_eff = kmer_len_q;
    end
    kbits = KW_W'(k_eff * SYMBOL_BITS);
    for (int i = 0; i < IDX_W; i++) begin
      kmask[i] = (KW_W'(i) < kbits);
    end
  end

  assign shifted = {window_q, sym_m};

  always_comb begin
    if (in_start) begin
      window_d = IDX_W'(sym_m);
      fill_d   = klen_t'(1);
    end else begin
      window_d = shifted[IDX_W-1:0];
      fill_d   = (fill_q < klen_t'(K_MAX)) ? fill_q + klen_t'(1) : fill_q;
    end
  end

  assign count_req = (fill_d >= k_eff);
  assign count_idx = window_d & kmask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      fill_q   <= '0;
    end else if (in_acc && !in_mode) begin
      window_q <= window_d;
      fill_q   <= fill_d;
    end
  end

  // Stage 1: table read returns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= in_mode || count_req;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_read_q <= in_mode;
      s1_idx_q  <= in_mode ? in_ridx : count_idx;
    end
  end

  // Count table
  ram_wr_t ram_wr;
  cnt_t    rd_data;

  khc_count_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_mode ? in_ridx : count_idx),
    .rd_data_o (rd_data)
  );

  // Forwarding from the last write covers a read taken in the same edge
  logic wr_vld_q;
  idx_t wr_idx_q;
  cnt_t wr_val_q;
  cnt_t old_cnt, new_cnt;
  cnt_t total_q, total_inc;
  logic do_count;

  assign old_cnt   = (wr_vld_q && (wr_idx_q == s1_idx_q)) ? wr_val_q : rd_data;
  assign new_cnt   = sat_inc(old_cnt);
  assign total_inc = sat_inc(total_q);
  assign do_count  = s1_adv && !s1_read_q;

  always_comb begin
    if (clearing_q) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = clr_addr_q;
      ram_wr.data = '0;
    end else begin
      ram_wr.en   = do_count;
      ram_wr.addr = s1_idx_q;
      ram_wr.data = new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_vld_q <= 1'b0;
      total_q  <= '0;
    end else if (do_count) begin
      wr_vld_q <= 1'b1;
      total_q  <= total_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_count) begin
      wr_idx_q <= s1_idx_q;
      wr_val_q <= new_cnt;
    end
  end

  // Output register
  logic [79:0] out_data_q;
  logic        out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_user_q <= s1_read_q;
      if (s1_read_q) begin
        out_data_q <= {total_q, old_cnt, s1_idx_q};
      end else begin
        out_data_q <= {total_inc, new_cnt, s1_idx_q};
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

### hw/rtl/khc_count_ram.sv
// khc_count_ram: count table, one write and one read port, registered read.
// Depends on khc_pkg.

module khc_count_ram (
  input  logic             clk_i,
  input  khc_pkg::ram_wr_t wr_i,
  input  logic             rd_en_i,
  input  khc_pkg::idx_t    rd_addr_i,
  output khc_pkg::cnt_t    rd_data_o
);
  import khc_pkg::*;

  cnt_t mem [DEPTH];
  cnt_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
